FILE: rtl/bgsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsr_pkg
// Shared types and codes of the bitmap glyph span renderer: command and
// register codes, the queued command beat, the config bundle and the result.
// ----------------------------------------------------------------------------
package bgsr_pkg;

  localparam int GLYPH_COUNT_DEF    = 256;
  localparam int MAX_GLYPH_ROWS_DEF = 16;
  localparam int COORD_BITS_DEF     = 12;
  localparam int QUEUE_DEPTH        = 2;

  localparam int COORD_OUT_W = 12;
  localparam int PATTERN_W   = 16;
  localparam int SPAN_W      = 17;

  // input command codes
  localparam logic [1:0] CMD_WRITE_ROW = 2'd0;
  localparam logic [1:0] CMD_DRAW      = 2'd1;
  localparam logic [1:0] CMD_SET_PEN   = 2'd2;

  // config register indexes; the color register (index 6) is accepted and dropped
  localparam logic [2:0] REG_GLYPH_WIDTH    = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_CHAR_GAP       = 3'd2;
  localparam logic [2:0] REG_STYLE_MODE     = 3'd3;
  localparam logic [2:0] REG_UNDERLINE_MODE = 3'd4;
  localparam logic [2:0] REG_STRIKE_MODE    = 3'd5;

  // underline / strike modes
  localparam logic [1:0] LINE_SINGLE = 2'd1;
  localparam logic [1:0] LINE_DOUBLE = 2'd2;

  localparam int STYLE_ITALIC_BIT = 0;
  localparam int STYLE_BOLD_BIT   = 1;

  localparam logic [4:0] DIM_MAX = 5'd16;

  typedef enum logic [1:0] {
    OP_WRITE_ROW,
    OP_DRAW,
    OP_SET_PEN
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [7:0]           ch;       // already reduced modulo the glyph count
    logic [3:0]           row;
    logic [PATTERN_W-1:0] pattern;
    logic signed [11:0]   px;
    logic signed [11:0]   py;
  } cmd_t;

  typedef struct packed {
    logic [4:0] width;      // clamped 1..16
    logic [4:0] height;     // clamped 1..max rows
    logic [4:0] gap;        // two's complement
    logic [1:0] style;
    logic [1:0] underline;
    logic [1:0] strike;
  } cfg_t;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_OUT_W-1:0] x;
    logic signed [COORD_OUT_W-1:0] y;
    logic [SPAN_W-1:0]             bits;
    logic signed [COORD_OUT_W-1:0] end_x;
    logic                          last;
  } res_t;

endpackage

FILE: rtl/bgsr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsr_fifo
// Small show-ahead queue; the head entry is visible while empty_o is low.
// ----------------------------------------------------------------------------
module bgsr_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = bgsr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/bgsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsr_front
// Input decode: classifies each beat, folds the char code into the store and
// drops beats that do nothing before they reach the command queue.
// ----------------------------------------------------------------------------
module bgsr_front #(
  parameter int GLYPH_COUNT    = bgsr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = bgsr_pkg::MAX_GLYPH_ROWS_DEF
) (
  input  logic               in_push_i,
  output logic               in_full_o,
  input  logic [1:0]         command_i,
  input  logic [7:0]         char_code_i,
  input  logic [3:0]         row_index_i,
  input  logic [15:0]        row_pattern_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  output logic               q_push_o,
  output bgsr_pkg::cmd_t     q_data_o,
  input  logic               q_full_i
);
  import bgsr_pkg::*;

  localparam int CHW = $clog2(GLYPH_COUNT);

  logic [CHW-1:0] ch_mod_tbl [256];
  logic           accept, keep;
  op_e            op;

  // char code modulo glyph count, as a constant lookup
  for (genvar c = 0; c < 256; c++) begin : g_mod
    assign ch_mod_tbl[c] = CHW'(c % GLYPH_COUNT);
  end

  assign in_full_o = q_full_i;
  assign accept    = in_push_i && !q_full_i;

  always_comb begin
    keep = 1'b0;
    op   = OP_DRAW;
    unique case (command_i)
      CMD_WRITE_ROW: begin
        op   = OP_WRITE_ROW;
        keep = ({1'b0, row_index_i} < 5'(MAX_GLYPH_ROWS));
      end
      CMD_DRAW: begin
        op   = OP_DRAW;
        keep = 1'b1;
      end
      CMD_SET_PEN: begin
        op   = OP_SET_PEN;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o         = accept && keep;
  assign q_data_o.op      = op;
  assign q_data_o.ch      = 8'(ch_mod_tbl[char_code_i]);
  assign q_data_o.row     = row_index_i;
  assign q_data_o.pattern = row_pattern_i;
  assign q_data_o.px      = pos_x_i;
  assign q_data_o.py      = pos_y_i;

endmodule

FILE: rtl/bgsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsr_back
// Execution side: owns the glyph memory and the pen, runs glyph-row writes
// and pen moves, and sequences a draw into row spans and then line beats.
// ----------------------------------------------------------------------------
module bgsr_back #(
  parameter int GLYPH_COUNT    = bgsr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = bgsr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int COORD_BITS     = bgsr_pkg::COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bgsr_pkg::cfg_t cfg_i,
  input  logic           cmd_empty_i,
  input  bgsr_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output bgsr_pkg::res_t res_o
);
  import bgsr_pkg::*;

  localparam int CHW   = $clog2(GLYPH_COUNT);
  localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_GLYPH_ROWS);
  localparam int CW    = COORD_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROWS  = 2'd1;
  localparam logic [1:0] S_LINES = 2'd2;

  function automatic logic [1:0] line_count(input logic [1:0] mode);
    logic [1:0] n;
    unique case (mode)
      LINE_SINGLE: n = 2'd1;
      LINE_DOUBLE: n = 2'd2;
      default:     n = 2'd0;
    endcase
    return n;
  endfunction

  logic [PATTERN_W-1:0] mem [DEPTH];
  logic [PATTERN_W-1:0] rd_data_q;
  logic [RW-1:0]        rd_row_q;
  logic                 rd_valid_q;

  logic [1:0]     state_q, state_d;
  logic [RW-1:0]  row_q;
  logic [1:0]     line_q;
  logic [CHW-1:0] ch_q;
  logic [CW-1:0]  pen_col_q, pen_row_q;

  logic          idle, mem_we, pen_set, draw_start;
  logic          span_push, line_push, rd_en, final_push, lines_left;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [4:0]    w, h;
  logic [1:0]    nu, ns, strike_idx;
  logic [2:0]    nl;

  logic [PATTERN_W-1:0] rev;
  logic [SPAN_W-1:0]    span_raw, span_bits;
  logic [CW-1:0]        slant, span_x, span_y, half, dy, line_y;
  logic                 span_last, line_last;

  assign w = cfg_i.width;
  assign h = cfg_i.height;

  assign idle       = (state_q == S_IDLE);
  assign cmd_pop_o  = idle && !cmd_empty_i;
  assign mem_we     = cmd_pop_o && (cmd_i.op == OP_WRITE_ROW);
  assign pen_set    = cmd_pop_o && (cmd_i.op == OP_SET_PEN);
  assign draw_start = cmd_pop_o && (cmd_i.op == OP_DRAW);

  assign wr_addr = AW'(cmd_i.ch[CHW-1:0]) * AW'(MAX_GLYPH_ROWS) + AW'(cmd_i.row);
  assign rd_addr = AW'(ch_q) * AW'(MAX_GLYPH_ROWS) + AW'(row_q);

  // in the row state, the read stage advances when it is empty or its span beat leaves
  assign span_push = rd_valid_q && !res_full_i;
  assign rd_en     = (state_q == S_ROWS) && (!rd_valid_q || span_push);

  assign nu         = line_count(cfg_i.underline);
  assign ns         = line_count(cfg_i.strike);
  assign nl         = {1'b0, nu} + {1'b0, ns};
  assign lines_left = ({1'b0, line_q} < nl);
  assign line_push  = (state_q == S_LINES) && !rd_valid_q && lines_left && !res_full_i;
  assign res_push_o = span_push || line_push;
  assign final_push = res_push_o && res_o.last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (draw_start) state_d = S_ROWS;
      S_ROWS:  if (rd_en && (row_q == RW'(h - 5'd1))) state_d = S_LINES;
      S_LINES: if (final_push) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // span of a row: pattern bit i lands on column w-1-i
  always_comb begin
    for (int i = 0; i < PATTERN_W; i++) begin
      rev[PATTERN_W-1-i] = rd_data_q[i];
    end
  end

  assign span_raw  = {1'b0, rev} >> (DIM_MAX - w);
  assign span_bits = cfg_i.style[STYLE_BOLD_BIT] ?
                     (span_raw | {span_raw[SPAN_W-2:0], 1'b0}) : span_raw;
  assign slant     = cfg_i.style[STYLE_ITALIC_BIT] ?
                     CW'((h - 5'd1 - 5'(rd_row_q)) >> 2) : '0;
  assign span_x    = pen_col_q + slant;
  assign span_y    = pen_row_q + CW'(rd_row_q);
  assign span_last = (rd_row_q == RW'(h - 5'd1)) && (nl == 3'd0);

  // underlines first, then strikes
  assign half       = CW'(h >> 1);
  assign strike_idx = line_q - nu;
  always_comb begin
    if (line_q < nu) begin
      dy = CW'(h) + CW'(2) + (line_q[0] ? CW'(2) : '0);
    end else if (ns == 2'd1) begin
      dy = half;
    end else begin
      dy = half - CW'(1) + (strike_idx[0] ? CW'(2) : '0);
    end
  end
  assign line_y    = pen_row_q + dy;
  assign line_last = ({1'b0, line_q} == nl - 3'd1);

  always_comb begin
    if (rd_valid_q) begin
      res_o.kind  = 1'b0;
      res_o.x     = COORD_OUT_W'(span_x);
      res_o.y     = COORD_OUT_W'(span_y);
      res_o.bits  = span_bits;
      res_o.end_x = '0;
      res_o.last  = span_last;
    end else begin
      res_o.kind  = 1'b1;
      res_o.x     = COORD_OUT_W'(pen_col_q - CW'(1));
      res_o.y     = COORD_OUT_W'(line_y);
      res_o.bits  = '0;
      res_o.end_x = COORD_OUT_W'(pen_col_q + CW'(w) + CW'(1));
      res_o.last  = line_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd_i.pattern;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_row_q  <= row_q;
    end
    if (draw_start) begin
      ch_q <= cmd_i.ch[CHW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_valid_q <= 1'b0;
      row_q      <= '0;
      line_q     <= '0;
      pen_col_q  <= '0;
      pen_row_q  <= '0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        rd_valid_q <= 1'b1;
      end else if (span_push) begin
        rd_valid_q <= 1'b0;
      end
      if (draw_start) begin
        row_q  <= '0;
        line_q <= '0;
      end else begin
        if (rd_en) row_q <= row_q + 1'b1;
        if (line_push) line_q <= line_q + 1'b1;
      end
      if (pen_set) begin
        pen_col_q <= CW'(cmd_i.px);
        pen_row_q <= CW'(cmd_i.py);
      end else if (final_push) begin
        pen_col_q <= pen_col_q + CW'(w) + CW'($signed(cfg_i.gap));
      end
    end
  end

endmodule

FILE: rtl/bitmap_glyph_span_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_span_renderer
// Bitmap font character generator: glyph-row writes fill the glyph memory,
// draws emit one span per glyph row and then underline / strike lines.
// Throughput: a draw emits one result per cycle off the glyph memory read
// port while the result queue has room; glyph-row writes and pen moves
// take effect as their command is popped. The 2-entry command queue lets
// input run ahead of a draw.
// Reset: asynchronous, active low; pen and config return to defaults, the
// glyph memory is not cleared.
// ----------------------------------------------------------------------------
module bitmap_glyph_span_renderer #(
  parameter int GLYPH_COUNT    = bgsr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = bgsr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int COORD_BITS     = bgsr_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command_i,
  input  logic [7:0]         char_code_i,
  input  logic [3:0]         row_index_i,
  input  logic [15:0]        row_pattern_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic signed [11:0] out_x_o,
  output logic signed [11:0] out_y_o,
  output logic [16:0]        span_bits_o,
  output logic signed [11:0] line_end_x_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bgsr_pkg::*;

  localparam logic [4:0] H_MAX   = 5'(MAX_GLYPH_ROWS);
  localparam logic [4:0] H_RESET = (MAX_GLYPH_ROWS < 8) ? 5'(MAX_GLYPH_ROWS) : 5'd8;

  function automatic logic [4:0] clamp_dim(input logic [4:0] v, input logic [4:0] hi);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  cfg_t cfg_q;
  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;

  assign cfg_ready_o = 1'b1;

  // sizes are clamped on write; the color register has no effect on results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= 5'd8;
      cfg_q.height    <= H_RESET;
      cfg_q.gap       <= 5'h1F;
      cfg_q.style     <= '0;
      cfg_q.underline <= '0;
      cfg_q.strike    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GLYPH_WIDTH:    cfg_q.width     <= clamp_dim(cfg_data_i[4:0], DIM_MAX);
        REG_GLYPH_HEIGHT:   cfg_q.height    <= clamp_dim(cfg_data_i[4:0], H_MAX);
        REG_CHAR_GAP:       cfg_q.gap       <= cfg_data_i[4:0];
        REG_STYLE_MODE:     cfg_q.style     <= cfg_data_i[1:0];
        REG_UNDERLINE_MODE: cfg_q.underline <= cfg_data_i[1:0];
        REG_STRIKE_MODE:    cfg_q.strike    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  bgsr_front #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS)
  ) u_front (
    .in_push_i    (push),
    .in_full_o    (full),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .row_index_i  (row_index_i),
    .row_pattern_i(row_pattern_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .q_push_o     (cmd_push),
    .q_data_o     (cmd_in),
    .q_full_i     (cmd_full)
  );

  bgsr_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  bgsr_back #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  bgsr_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head),
    .empty_o(empty)
  );

  assign kind_o       = res_head.kind;
  assign out_x_o      = res_head.x;
  assign out_y_o      = res_head.y;
  assign span_bits_o  = res_head.bits;
  assign line_end_x_o = res_head.end_x;
  assign last_o       = res_head.last;

endmodule

FILE: rtl/bgsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsr_checker
// Port-level checks on the result side of the glyph span renderer.
// ----------------------------------------------------------------------------
module bgsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        kind_o,
  input logic [11:0] out_x_o,
  input logic [11:0] out_y_o,
  input logic [16:0] span_bits_o,
  input logic [11:0] line_end_x_o,
  input logic        last_o
);

  // nothing is offered while reset is applied
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result offered during reset");

  // a waiting result beat holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(out_x_o) &&
                          $stable(out_y_o) && $stable(span_bits_o) &&
                          $stable(line_end_x_o) && $stable(last_o)))
    else $error("waiting result changed");

  // inside a character, a line is followed only by more lines
  a_line_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o && !last_o) |=> (empty || kind_o))
    else $error("span after line within a character");

  // all lines of one character share their horizontal extent
  a_line_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o && !last_o) |=>
      (empty || (out_x_o == $past(out_x_o) && line_end_x_o == $past(line_end_x_o))))
    else $error("line extent changed within a character");

endmodule

bind bitmap_glyph_span_renderer bgsr_checker u_bgsr_checker (.*);

FILE: tb/sv/bitmap_glyph_span_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_glyph_span_renderer_tb
// Self-checking bench for the glyph span renderer. A short scripted run
// covers the clamps, wrap points, styles and line modes. Random phases
// follow, each under its own register setting, mixing glyph fills, draws,
// pen moves and dead commands. A local model of the glyph memory, pen and
// registers predicts every span and line, and each result beat is compared
// in order. Both handshakes stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module bitmap_glyph_span_renderer_tb;
  import bgsr_pkg::*;

  localparam int          LIMIT_CYCLES  = 600000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          POOL_SIZE     = 12;
  localparam int          PHASES        = 6;
  localparam int          PHASE_BEATS   = 75;
  localparam logic [1:0]  CMD_NONE      = 2'd3;
  localparam logic [2:0]  REG_DRAW_COLOR = 3'd6;
  localparam logic [2:0]  REG_SPARE     = 3'd7;
  localparam logic [1:0]  LINE_NONE     = 2'd0;
  localparam logic [1:0]  LINE_RSVD     = 2'd3;
  localparam logic [1:0]  STYLE_NORMAL  = 2'd0;
  localparam logic [1:0]  STYLE_BOLD    = 2'd2;
  localparam logic [1:0]  STYLE_ITALIC_BOLD = 2'd3;
  localparam logic        KIND_SPAN     = 1'b0;
  localparam logic        KIND_LINE     = 1'b1;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [3:0]  row;
    logic [15:0] pat;
    logic [11:0] px;
    logic [11:0] py;
  } glyph_cmd_t;

  typedef struct {
    bit          is_reg;
    logic [2:0]  idx;
    logic [31:0] data;
    glyph_cmd_t  beat;
    bit          pinned;
    res_t        pin;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [1:0]         command_i;
  logic [7:0]         char_code_i;
  logic [3:0]         row_index_i;
  logic [15:0]        row_pattern_i;
  logic signed [11:0] pos_x_i;
  logic signed [11:0] pos_y_i;
  logic               empty;
  logic               pop;
  logic               kind_o;
  logic signed [11:0] out_x_o;
  logic signed [11:0] out_y_o;
  logic [16:0]        span_bits_o;
  logic signed [11:0] line_end_x_o;
  logic               last_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  bitmap_glyph_span_renderer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .row_index_i  (row_index_i),
    .row_pattern_i(row_pattern_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .span_bits_o  (span_bits_o),
    .line_end_x_o (line_end_x_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // local copy of the block state
  logic [15:0] glyph_rom   [GLYPH_COUNT_DEF*MAX_GLYPH_ROWS_DEF];
  logic [15:0] glyph_known [GLYPH_COUNT_DEF];
  logic [11:0] pen_x, pen_y;
  logic [4:0]  cfg_w, cfg_h, cfg_gap;
  logic [1:0]  cfg_style, cfg_ul, cfg_st;
  logic [31:0] cfg_color;

  res_t        spans_due [$];
  script_row_t script [$];
  logic [7:0]  char_pool [POOL_SIZE];
  bit          calm;
  int          mismatches;
  int          cycles;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still due", $time, spans_due.size());
      $display("bitmap_glyph_span_renderer_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [4:0] clamp_dim(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic res_t mk_res(input logic kind, input logic [11:0] x, input logic [11:0] y,
                                  input logic [16:0] bits, input logic [11:0] end_x);
    res_t r;
    r.kind  = kind;
    r.x     = x;
    r.y     = y;
    r.bits  = bits;
    r.end_x = end_x;
    r.last  = 1'b0;
    return r;
  endfunction

  // append one expected result beat
  task automatic queue_due(input res_t r);
    spans_due = {spans_due, r};
  endtask

  task automatic push_line(input logic [11:0] y, input logic [4:0] w);
    queue_due(mk_res(KIND_LINE, pen_x - 12'd1, y, '0, pen_x + 12'(w) + 12'd1));
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_GLYPH_WIDTH:    cfg_w     = data[4:0];
      REG_GLYPH_HEIGHT:   cfg_h     = data[4:0];
      REG_CHAR_GAP:       cfg_gap   = data[4:0];
      REG_STYLE_MODE:     cfg_style = data[1:0];
      REG_UNDERLINE_MODE: cfg_ul    = data[1:0];
      REG_STRIKE_MODE:    cfg_st    = data[1:0];
      REG_DRAW_COLOR:     cfg_color = data;
      default: ;
    endcase
  endtask

  // expected spans and lines of one accepted command beat
  task automatic predict_beat(input glyph_cmd_t c);
    logic [4:0]  w, h;
    logic [15:0] g;
    logic [16:0] bits;
    logic [11:0] x;
    case (c.cmd)
      CMD_WRITE_ROW: begin
        glyph_rom[{c.ch, c.row}] = c.pat;
        glyph_known[c.ch][c.row] = 1'b1;
      end
      CMD_SET_PEN: begin
        pen_x = c.px;
        pen_y = c.py;
      end
      CMD_DRAW: begin
        w = clamp_dim(cfg_w);
        h = clamp_dim(cfg_h);
        for (int j = 0; j < h; j++) begin
          g = glyph_rom[{c.ch, 4'(j)}];
          bits = '0;
          // pattern bit 0 is the rightmost pixel
          for (int i = 0; i < w; i++)
            if (g[i]) bits[w - 1 - i] = 1'b1;
          if (cfg_style[STYLE_BOLD_BIT]) bits = bits | (bits << 1);
          x = pen_x;
          if (cfg_style[STYLE_ITALIC_BIT]) x = x + 12'((h - 1 - j) / 4);
          queue_due(mk_res(KIND_SPAN, x, pen_y + 12'(j), bits, '0));
        end
        if (cfg_ul == LINE_SINGLE || cfg_ul == LINE_DOUBLE)
          push_line(pen_y + 12'(h) + 12'd2, w);
        if (cfg_ul == LINE_DOUBLE)
          push_line(pen_y + 12'(h) + 12'd4, w);
        if (cfg_st == LINE_SINGLE)
          push_line(pen_y + 12'(h >> 1), w);
        if (cfg_st == LINE_DOUBLE) begin
          push_line(pen_y + 12'(h >> 1) - 12'd1, w);
          push_line(pen_y + 12'(h >> 1) + 12'd1, w);
        end
        spans_due[spans_due.size() - 1].last = 1'b1;
        pen_x = pen_x + 12'(w) + {{7{cfg_gap[4]}}, cfg_gap};
      end
      default: ;
    endcase
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [31:0] data);
    script_row_t s;
    s = '{default: '0};
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    script = {script, s};
  endtask

  task automatic add_beat(input logic [1:0] cmd, input logic [7:0] ch, input logic [3:0] row,
                          input logic [15:0] pat, input logic [11:0] px, input logic [11:0] py);
    script_row_t s;
    s = '{default: '0};
    s.beat = '{cmd: cmd, ch: ch, row: row, pat: pat, px: px, py: py};
    script = {script, s};
  endtask

  // single-span draw whose result is written out by hand
  task automatic pin_span(input logic [11:0] x, input logic [11:0] y, input logic [16:0] bits);
    script[script.size() - 1].pinned   = 1'b1;
    script[script.size() - 1].pin      = mk_res(KIND_SPAN, x, y, bits, '0);
    script[script.size() - 1].pin.last = 1'b1;
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // wait until every result is out and the command queue has emptied
  task automatic settle();
    push = 1'b0;
    while (spans_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    settle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_beat(input glyph_cmd_t c);
    command_i     = c.cmd;
    char_code_i   = c.ch;
    row_index_i   = c.row;
    row_pattern_i = c.pat;
    pos_x_i       = c.px;
    pos_y_i       = c.py;
    push          = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_beat(c);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] with_noise(input logic [31:0] v, input int nbits);
    logic [31:0] m;
    m = (32'd1 << nbits) - 32'd1;
    return ($urandom & ~m) | (v & m);
  endfunction

  // draws only touch glyph rows already loaded; a draw that would not
  // becomes the fill of its first missing row
  function automatic glyph_cmd_t pick_beat();
    glyph_cmd_t c;
    int         r;
    int         miss;
    logic [4:0] h;
    c.ch  = 8'($urandom);
    c.row = 4'($urandom);
    c.px  = 12'($urandom);
    c.py  = 12'($urandom);
    r = $urandom_range(0, 9);
    c.pat = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
    if ($urandom_range(0, 3) != 0) c.ch = char_pool[$urandom_range(0, POOL_SIZE - 1)];
    r = $urandom_range(0, 99);
    if (r < 25) begin
      c.cmd = CMD_WRITE_ROW;
    end else if (r < 72) begin
      c.cmd = CMD_DRAW;
      h = clamp_dim(cfg_h);
      miss = -1;
      for (int j = h - 1; j >= 0; j--)
        if (!glyph_known[c.ch][j]) miss = j;
      if (miss >= 0) begin
        c.cmd = CMD_WRITE_ROW;
        c.row = 4'(miss);
      end
    end else if (r < 92) begin
      c.cmd = CMD_SET_PEN;
    end else begin
      c.cmd = CMD_NONE;
    end
    return c;
  endfunction

  // result side: random pop stalls, compare on every accepted beat
  initial begin
    int   stall;
    res_t got, want;
    stall = 0;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (calm) stall = 0;
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 6);
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        got = mk_res(kind_o, out_x_o, out_y_o, span_bits_o, line_end_x_o);
        got.last = last_o;
        if (spans_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result got kind=%0h x=%h y=%h bits=%h end=%h last=%0h",
                   $time, got.kind, got.x, got.y, got.bits, got.end_x, got.last);
        end else begin
          want = spans_due.pop_front();
          if (got !== want) begin
            mismatches++;
            $display({"%0t: mismatch exp kind=%0h x=%h y=%h bits=%h end=%h last=%0h",
                      " got kind=%0h x=%h y=%h bits=%h end=%h last=%0h"}, $time,
                     want.kind, want.x, want.y, want.bits, want.end_x, want.last,
                     got.kind, got.x, got.y, got.bits, got.end_x, got.last);
          end
        end
      end
    end
  end

  initial begin
    logic [4:0] w, h;
    logic [1:0] sty, ul, st;
    logic [4:0] gap;
    cycles        = 0;
    mismatches    = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    command_i     = CMD_WRITE_ROW;
    char_code_i   = '0;
    row_index_i   = '0;
    row_pattern_i = '0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_GLYPH_WIDTH;
    cfg_data_i    = '0;
    pen_x         = '0;
    pen_y         = '0;
    cfg_w         = 5'd8;
    cfg_h         = 5'd8;
    cfg_gap       = 5'h1F;
    cfg_style     = STYLE_NORMAL;
    cfg_ul        = LINE_NONE;
    cfg_st        = LINE_NONE;
    cfg_color     = 32'hFFFF_FFFF;
    foreach (glyph_known[k]) glyph_known[k] = '0;
    foreach (char_pool[k]) char_pool[k] = 8'($urandom);
    char_pool[0] = 8'h00;
    char_pool[1] = 8'hFF;

    // scripted part: one-row glyphs so every draw stays on loaded rows
    add_reg(REG_GLYPH_WIDTH, 32'd16);
    add_reg(REG_GLYPH_HEIGHT, 32'd1);
    add_beat(CMD_WRITE_ROW, 8'h00, 4'd0, 16'hFFFF, 12'h000, 12'h000);
    add_beat(CMD_DRAW, 8'h00, 4'd0, 16'h0000, 12'h000, 12'h000);
    pin_span(12'h000, 12'h000, 17'h0FFFF);
    add_beat(CMD_WRITE_ROW, 8'hFF, 4'd0, 16'h0001, 12'hFFF, 12'hFFF);
    add_beat(CMD_SET_PEN, 8'h00, 4'd0, 16'h0000, 12'h800, 12'h7FF);
    add_beat(CMD_DRAW, 8'hFF, 4'hF, 16'hFFFF, 12'hFFF, 12'h000);
    pin_span(12'h800, 12'h7FF, 17'h08000);
    add_beat(CMD_WRITE_ROW, 8'hFF, 4'hF, 16'hAAAA, 12'h000, 12'h000);
    add_beat(CMD_NONE, 8'hA5, 4'h5, 16'h5555, 12'h555, 12'hAAA);  // dead command
    add_beat(CMD_WRITE_ROW, 8'h5A, 4'd0, 16'h8000, 12'h000, 12'h000);
    add_beat(CMD_SET_PEN, 8'h00, 4'd0, 16'h0000, 12'h7FF, 12'hFFF);
    add_beat(CMD_DRAW, 8'h5A, 4'd0, 16'h0000, 12'h000, 12'h000);
    pin_span(12'h7FF, 12'hFFF, 17'h00001);
    add_beat(CMD_DRAW, 8'h5A, 4'd0, 16'h0000, 12'h000, 12'h000);  // pen wraps
    add_reg(REG_STYLE_MODE, 32'(STYLE_ITALIC_BOLD));
    add_reg(REG_UNDERLINE_MODE, 32'(LINE_DOUBLE));
    add_reg(REG_STRIKE_MODE, 32'(LINE_DOUBLE));
    add_beat(CMD_DRAW, 8'hFF, 4'd0, 16'h0000, 12'h000, 12'h000);
    add_reg(REG_UNDERLINE_MODE, 32'(LINE_RSVD));
    add_reg(REG_STRIKE_MODE, 32'(LINE_RSVD));
    add_reg(REG_GLYPH_WIDTH, 32'd0);
    add_reg(REG_GLYPH_HEIGHT, 32'd0);
    add_beat(CMD_DRAW, 8'h00, 4'd0, 16'h0000, 12'h000, 12'h000);
    add_reg(REG_CHAR_GAP, 32'd15);
    add_reg(REG_DRAW_COLOR, 32'h0000_0000);
    add_reg(REG_SPARE, 32'($urandom));
    add_reg(REG_UNDERLINE_MODE, 32'(LINE_SINGLE));
    add_reg(REG_STRIKE_MODE, 32'(LINE_SINGLE));
    add_beat(CMD_DRAW, 8'hFF, 4'd0, 16'h0000, 12'h000, 12'h000);
    add_reg(REG_CHAR_GAP, 32'h18);
    add_reg(REG_GLYPH_WIDTH, 32'd31);
    add_beat(CMD_DRAW, 8'h00, 4'd0, 16'h0000, 12'h000, 12'h000);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        write_reg(script[k].idx, script[k].data);
      end else begin
        idle_gap();
        send_beat(script[k].beat);
        if (script[k].pinned) begin
          void'(spans_due.pop_back());
          queue_due(script[k].pin);
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        w = 5'd16; h = 5'd16; gap = 5'h18; sty = STYLE_ITALIC_BOLD;
        ul = LINE_DOUBLE; st = LINE_DOUBLE;
      end else if (ph == 1) begin
        w = 5'd1; h = 5'd1; gap = 5'h0F; sty = STYLE_BOLD; ul = LINE_SINGLE; st = LINE_SINGLE;
      end else begin
        // mostly small glyphs, now and then anything the field holds
        w   = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 6)) : 5'($urandom);
        h   = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 4)) : 5'($urandom);
        gap = 5'($urandom);
        sty = 2'($urandom);
        ul  = 2'($urandom);
        st  = 2'($urandom);
      end
      write_reg(REG_GLYPH_WIDTH, with_noise(32'(w), 5));
      write_reg(REG_GLYPH_HEIGHT, with_noise(32'(h), 5));
      write_reg(REG_CHAR_GAP, with_noise(32'(gap), 5));
      write_reg(REG_STYLE_MODE, with_noise(32'(sty), 2));
      write_reg(REG_UNDERLINE_MODE, with_noise(32'(ul), 2));
      write_reg(REG_STRIKE_MODE, with_noise(32'(st), 2));
      write_reg(REG_DRAW_COLOR, $urandom);
      calm = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 2 && n == PHASE_BEATS / 2) settle();
        idle_gap();
        send_beat(pick_beat());
      end
    end

    push = 1'b0;
    while (spans_due.size() != 0) @(negedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && spans_due.size() == 0) begin
      $display("bitmap_glyph_span_renderer_tb OK");
    end else begin
      $display("bitmap_glyph_span_renderer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bgsr_pkg.sv
rtl/bgsr_fifo.sv
rtl/bgsr_front.sv
rtl/bgsr_back.sv
rtl/bitmap_glyph_span_renderer.sv
rtl/bgsr_checker.sv
tb/sv/bitmap_glyph_span_renderer_tb.sv
